FILE: rtl/dmck_pkg.sv
// Package for the dual Monod cell kinetics block: beat types, register
// indexes, fixed-point constants and the signed saturation helper.
`default_nettype none

package dmck_pkg;

	// Width of every concentration, rate and delta field (Q16.16).
	localparam int unsigned DATA_W = 32;

	// Configuration port index width and register indexes.
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_GROWTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_YIELD       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAINTENANCE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OXY_HALF    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NIT_HALF    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd6;

	// Reset value of the yield coefficient: 1.0 in Q16.16.
	localparam logic [DATA_W-1:0] YIELD_RESET = 32'h0001_0000;

	// The constant 1.15 in Q16.16.
	localparam logic [16:0] ONE_FIFTEEN_Q16 = 17'd75366;

	// Quotient bits of the Monod fraction divider and the yield dividers.
	localparam int unsigned FRAC_QW = 17;
	localparam int unsigned YLD_QW  = 48;

	// One cell beat entering the block.
	typedef struct packed {
		logic [DATA_W-1:0] oxygen_conc;
		logic [DATA_W-1:0] nitrite_conc;
		logic [DATA_W-1:0] biomass_density;
		logic              ghost_cell;
		logic              last_cell;
	} cell_beat_t;

	// One result beat leaving the block.
	typedef struct packed {
		logic signed [DATA_W-1:0] nitrite_delta;
		logic signed [DATA_W-1:0] oxygen_delta;
		logic signed [DATA_W-1:0] nitrate_delta;
		logic                     reaction_valid;
		logic signed [DATA_W-1:0] growth_rate;
		logic                     growth_valid;
		logic                     last_out;
	} rxn_beat_t;

	localparam logic signed [DATA_W-1:0] INT32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] INT32_MIN = 32'sh8000_0000;

	// Clamp a signed 64-bit value to the signed 32-bit range.
	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
		logic signed [DATA_W-1:0] r;
		if (v > 64'sh0000_0000_7FFF_FFFF) begin
			r = INT32_MAX;
		end else if (v < -64'sh0000_0000_8000_0000) begin
			r = INT32_MIN;
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/dual_monod_cell_kinetics.sv
// Dual Monod cell kinetics: one grid cell per clock cycle in, one result per cell out,
// in order. The pipeline has one input stage, 17 stages of the Monod fraction dividers,
// four multiply stages, 48 stages of the two yield dividers and two output stages; the
// two long divider pipelines make up most of its depth. The pipeline advances as a
// whole whenever the output register is empty or being taken, so cell_stall follows
// rxn_stall only while a result waits. Configuration writes are taken at any time but
// must only be made while no cell is in flight.
`default_nettype none

module dual_monod_cell_kinetics
	import dmck_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cell_valid,
	output logic                      cell_stall,
	input  wire cell_beat_t           cell_data,
	output logic                      rxn_valid,
	input  wire logic                 rxn_stall,
	output rxn_beat_t                 rxn_data,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DATA_W-1:0]    cfg_data
);

	localparam int unsigned FRAC_SIDE_W = DATA_W + 4;
	localparam int unsigned YLD_SIDE_W  = 47 + 48 + DATA_W + 4;

	// Configuration registers.
	logic [DATA_W-1:0] max_growth_q;
	logic [DATA_W-1:0] yield_q;
	logic [DATA_W-1:0] maint_q;
	logic [DATA_W-1:0] decay_q;
	logic [DATA_W-1:0] oxy_half_q;
	logic [DATA_W-1:0] nit_half_q;
	logic [1:0]        mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_growth_q <= '0;
			yield_q      <= YIELD_RESET;
			maint_q      <= '0;
			decay_q      <= '0;
			oxy_half_q   <= '0;
			nit_half_q   <= '0;
			mode_q       <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_GROWTH:  max_growth_q <= cfg_data;
				REG_YIELD:       yield_q      <= cfg_data;
				REG_MAINTENANCE: maint_q      <= cfg_data;
				REG_DECAY:       decay_q      <= cfg_data;
				REG_OXY_HALF:    oxy_half_q   <= cfg_data;
				REG_NIT_HALF:    nit_half_q   <= cfg_data;
				REG_MODE:        mode_q       <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// The whole pipeline moves when the output register is free or taken.
	logic en;
	assign en         = !rxn_valid || !rxn_stall;
	assign cell_stall = !en;

	// Stage 1: capture the beat and form the Monod denominators.
	logic [DATA_W-1:0] o_s1, d_s1;
	logic [DATA_W:0]   so_s1, sn_s1;
	logic [DATA_W-1:0] n_s1;
	logic              ghost_s1, last_s1, v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= cell_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			o_s1     <= cell_data.oxygen_conc;
			n_s1     <= cell_data.nitrite_conc;
			d_s1     <= cell_data.biomass_density;
			so_s1    <= {1'b0, cell_data.oxygen_conc} + {1'b0, oxy_half_q};
			sn_s1    <= {1'b0, cell_data.nitrite_conc} + {1'b0, nit_half_q};
			ghost_s1 <= cell_data.ghost_cell;
			last_s1  <= cell_data.last_cell;
		end
	end

	// Monod fractions C*65536/(K+C), one quotient bit per stage.
	logic [FRAC_QW-1:0]     fo_raw, fn_raw;
	logic [FRAC_SIDE_W-1:0] frac_side_in, frac_side_out;
	logic                   v_f;

	dmck_div #(.NW(DATA_W + 16), .DW(DATA_W + 1), .QW(FRAC_QW)) u_div_oxy (
		.clk(clk), .en(en), .num({o_s1, 16'h0000}), .den(so_s1), .quo(fo_raw)
	);

	dmck_div #(.NW(DATA_W + 16), .DW(DATA_W + 1), .QW(FRAC_QW)) u_div_nit (
		.clk(clk), .en(en), .num({n_s1, 16'h0000}), .den(sn_s1), .quo(fn_raw)
	);

	assign frac_side_in = {d_s1, ghost_s1, last_s1, (so_s1 == '0), (sn_s1 == '0)};

	dmck_delay #(.W(FRAC_SIDE_W), .DEPTH(FRAC_QW)) u_dly_frac (
		.clk(clk), .arst_n(arst_n), .en(en), .d(frac_side_in), .q(frac_side_out)
	);

	dmck_delay #(.W(1), .DEPTH(FRAC_QW)) u_vld_frac (
		.clk(clk), .arst_n(arst_n), .en(en), .d(v_s1), .q(v_f)
	);

	logic [DATA_W-1:0]  d_f;
	logic               ghost_f, last_f, zo_f, zn_f;
	logic [FRAC_QW-1:0] fo_f, fn_f;
	assign {d_f, ghost_f, last_f, zo_f, zn_f} = frac_side_out;
	assign fo_f = zo_f ? '0 : fo_raw;
	assign fn_f = zn_f ? '0 : fn_raw;

	// Stage 2: mu*fn and the maintenance term m*fo/2^16.
	logic [DATA_W+FRAC_QW-1:0] mfn_full, t2_full;
	logic [47:0]               mfn_s2;
	logic [DATA_W-1:0]         t2_s2, d_s2;
	logic [FRAC_QW-1:0]        fo_s2;
	logic                      ghost_s2, last_s2, v_s2;

	assign mfn_full = max_growth_q * fn_f;
	assign t2_full  = maint_q * fo_f;

	always_ff @(posedge clk) begin
		if (en) begin
			mfn_s2   <= mfn_full[47:0];
			t2_s2    <= t2_full[47:16];
			fo_s2    <= fo_f;
			d_s2     <= d_f;
			ghost_s2 <= ghost_f;
			last_s2  <= last_f;
		end
	end

	// Stage 3: the growth term t1 = mu*fn*fo/2^32.
	logic [48+FRAC_QW-1:0] t1_full;
	logic [DATA_W-1:0]     t1_s3, t2_s3, d_s3;
	logic                  ghost_s3, last_s3, v_s3;

	assign t1_full = mfn_s2 * fo_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			t1_s3    <= t1_full[63:32];
			t2_s3    <= t2_s2;
			d_s3     <= d_s2;
			ghost_s3 <= ghost_s2;
			last_s3  <= last_s2;
		end
	end

	// Stage 4: scale by biomass, saturate growth, and form the net rate.
	logic [63:0]        g_full, e_full;
	logic signed [33:0] net;
	logic [46:0]        g_s4;
	logic [47:0]        e_s4;
	logic [DATA_W-1:0]  gr_s4;
	logic               ghost_s4, last_s4, v_s4;

	assign g_full = t1_s3 * d_s3;
	assign e_full = t2_s3 * d_s3;
	assign net    = $signed({2'b00, t1_s3}) - $signed({2'b00, t2_s3})
		- $signed({2'b00, decay_q});

	always_ff @(posedge clk) begin
		if (en) begin
			g_s4     <= g_full[63] ? '1 : g_full[62:16];
			e_s4     <= e_full[63:16];
			gr_s4    <= sat32(64'(net));
			ghost_s4 <= ghost_s3;
			last_s4  <= last_s3;
		end
	end

	// Stage 5: g*1.15 ahead of the yield divisions.
	logic [63:0]       p_s5;
	logic [46:0]       g_s5;
	logic [47:0]       e_s5;
	logic [DATA_W-1:0] gr_s5;
	logic              ghost_s5, last_s5, v_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			p_s5     <= g_s4 * ONE_FIFTEEN_Q16;
			g_s5     <= g_s4;
			e_s5     <= e_s4;
			gr_s5    <= gr_s4;
			ghost_s5 <= ghost_s4;
			last_s5  <= last_s4;
		end
	end

	// A zero yield counts as the smallest nonzero value. A quotient that would
	// not fit in the divider is flagged here and clamped at the far end.
	logic [DATA_W-1:0] y_eff;
	logic              ovf_q, ovf_a;
	assign y_eff = (yield_q == '0) ? DATA_W'(1) : yield_q;
	assign ovf_q = DATA_W'(g_s5[46:32]) >= y_eff;
	assign ovf_a = DATA_W'(p_s5[63:48]) >= y_eff;

	logic [YLD_QW-1:0]     q_quo, a_quo;
	logic [YLD_SIDE_W-1:0] yld_side_in, yld_side_out;
	logic                  v_y;

	dmck_div #(.NW(63), .DW(DATA_W), .QW(YLD_QW)) u_div_q (
		.clk(clk), .en(en), .num({g_s5, 16'h0000}), .den(y_eff), .quo(q_quo)
	);

	dmck_div #(.NW(64), .DW(DATA_W), .QW(YLD_QW)) u_div_a (
		.clk(clk), .en(en), .num(p_s5), .den(y_eff), .quo(a_quo)
	);

	assign yld_side_in = {g_s5, e_s5, gr_s5, ovf_q, ovf_a, ghost_s5, last_s5};

	dmck_delay #(.W(YLD_SIDE_W), .DEPTH(YLD_QW)) u_dly_yld (
		.clk(clk), .arst_n(arst_n), .en(en), .d(yld_side_in), .q(yld_side_out)
	);

	dmck_delay #(.W(1), .DEPTH(YLD_QW)) u_vld_yld (
		.clk(clk), .arst_n(arst_n), .en(en), .d(v_s5), .q(v_y)
	);

	logic [46:0]       g_y;
	logic [47:0]       e_y;
	logic [DATA_W-1:0] gr_y;
	logic              ovf_q_y, ovf_a_y, ghost_y, last_y;
	assign {g_y, e_y, gr_y, ovf_q_y, ovf_a_y, ghost_y, last_y} = yld_side_out;

	// Stage 6: compare 1.15*g/Y with g, cap the surplus, clamp the nitrogen term.
	logic [48:0] a_cl, a_minus_g, g_minus_a;
	logic        a_ge_g;
	logic        ge_s6, qbig_s6, ghost_s6, last_s6, v_s6;
	logic [48:0] dmag_s6;
	logic [47:0] e_s6;
	logic [30:0] qlo_s6;
	logic [DATA_W-1:0] gr_s6;

	assign a_cl      = ovf_a_y ? {1'b1, 48'h0} : {1'b0, a_quo};
	assign a_ge_g    = a_cl >= {2'b00, g_y};
	assign a_minus_g = a_cl - {2'b00, g_y};
	assign g_minus_a = {2'b00, g_y} - a_cl;

	always_ff @(posedge clk) begin
		if (en) begin
			ge_s6    <= a_ge_g;
			if (a_ge_g) begin
				dmag_s6 <= (a_minus_g > {8'h0, 1'b1, 40'h0}) ? {8'h0, 1'b1, 40'h0}
					: a_minus_g;
			end else begin
				dmag_s6 <= g_minus_a;
			end
			e_s6     <= e_y;
			qbig_s6  <= ovf_q_y || (q_quo[YLD_QW-1:31] != '0);
			qlo_s6   <= q_quo[30:0];
			gr_s6    <= gr_y;
			ghost_s6 <= ghost_y;
			last_s6  <= last_y;
		end
	end

	// Stage 7: saturate, apply the enables and hold the result beat.
	logic signed [50:0] oxy_cons_neg;
	logic               rvalid, gvalid;
	rxn_beat_t          beat;

	assign oxy_cons_neg = ge_s6
		? -($signed({2'b00, dmag_s6}) + $signed({3'b000, e_s6}))
		: ($signed({2'b00, dmag_s6}) - $signed({3'b000, e_s6}));
	assign rvalid = mode_q[0] && !ghost_s6;
	assign gvalid = mode_q[1];

	always_comb begin
		beat = '0;
		beat.reaction_valid = rvalid;
		beat.growth_valid   = gvalid;
		beat.last_out       = last_s6;
		if (rvalid) begin
			beat.nitrite_delta = qbig_s6 ? INT32_MIN : -$signed({1'b0, qlo_s6});
			beat.nitrate_delta = qbig_s6 ? INT32_MAX : $signed({1'b0, qlo_s6});
			beat.oxygen_delta  = sat32(64'(oxy_cons_neg));
		end
		if (gvalid) begin
			beat.growth_rate = gr_s6;
		end
	end

	// Valid bits for the short stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			rxn_valid <= 1'b0;
		end else if (en) begin
			v_s2      <= v_f;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			v_s5      <= v_s4;
			v_s6      <= v_y;
			rxn_valid <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rxn_data <= beat;
		end
	end

	// A suppressed reaction carries no deltas.
	a_no_delta_when_off: assert property (@(posedge clk) disable iff (!arst_n)
		(rxn_valid && !rxn_data.reaction_valid) |->
		(rxn_data.nitrite_delta == '0 && rxn_data.oxygen_delta == '0
		&& rxn_data.nitrate_delta == '0))
		else $error("deltas present while reaction is suppressed");

	// Nitrate produced mirrors nitrite consumed, up to saturation.
	a_nitrogen_balance: assert property (@(posedge clk) disable iff (!arst_n)
		rxn_valid |-> ((rxn_data.nitrate_delta + rxn_data.nitrite_delta == '0)
		|| (rxn_data.nitrite_delta == INT32_MIN && rxn_data.nitrate_delta == INT32_MAX)))
		else $error("nitrite and nitrate deltas out of balance");

	// Nitrate never decreases.
	a_nitrate_sign: assert property (@(posedge clk) disable iff (!arst_n)
		rxn_valid |-> !rxn_data.nitrate_delta[DATA_W-1])
		else $error("negative nitrate delta");

	// Growth rate is cleared when growth mode is off.
	a_no_growth_when_off: assert property (@(posedge clk) disable iff (!arst_n)
		(rxn_valid && !rxn_data.growth_valid) |-> (rxn_data.growth_rate == '0))
		else $error("growth rate present while growth mode is off");

endmodule

`default_nettype wire

FILE: rtl/dmck_delay.sv
// Enabled shift line that carries side data and valid bits alongside the
// divider pipelines. Depends on nothing outside this file.
`default_nettype none

module dmck_delay #(
	parameter int unsigned W     = 8,
	parameter int unsigned DEPTH = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire logic [W-1:0] d,
	output logic      [W-1:0] q
);

	logic [W-1:0] line_s [DEPTH];

	// Every tap moves one place whenever the pipeline advances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				line_s[i] <= '0;
			end
		end else if (en) begin
			line_s[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				line_s[i] <= line_s[i-1];
			end
		end
	end

	assign q = line_s[DEPTH-1];

endmodule

`default_nettype wire

FILE: rtl/dmck_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on nothing outside this file.
`default_nettype none

module dmck_div #(
	parameter int unsigned NW = 48,
	parameter int unsigned DW = 33,
	parameter int unsigned QW = 17
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic      [QW-1:0] quo
);

	// The upper NW-QW dividend bits seed the remainder; the caller makes sure
	// they are below the divisor whenever the quotient is used.
	logic [DW-1:0] rem_s  [QW];
	logic [DW-1:0] den_s  [QW];
	logic [QW-1:0] work_s [QW];

	for (genvar j = 0; j < QW; j++) begin : g_step
		logic [DW-1:0] rem_in;
		logic [DW-1:0] den_in;
		logic [QW-1:0] work_in;
		logic [DW:0]   trial;
		logic [DW+1:0] diff;
		logic          take;

		if (j == 0) begin : g_first
			assign rem_in  = DW'(num[NW-1:QW]);
			assign den_in  = den;
			assign work_in = num[QW-1:0];
		end else begin : g_next
			assign rem_in  = rem_s[j-1];
			assign den_in  = den_s[j-1];
			assign work_in = work_s[j-1];
		end

		// Shift in the next dividend bit and subtract the divisor if it fits.
		assign trial = {rem_in, work_in[QW-1]};
		assign diff  = {1'b0, trial} - {2'b00, den_in};
		assign take  = ~diff[DW+1];

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= take ? diff[DW-1:0] : trial[DW-1:0];
				den_s[j]  <= den_in;
				work_s[j] <= {work_in[QW-2:0], take};
			end
		end
	end

	assign quo = work_s[QW-1];

endmodule

`default_nettype wire
